// ----- design/assert_macros.svh -----
// assertion macros for the occupancy grid block
// needs a clock named clk and a reset named rst in the using scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("same-cycle check failed");

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("next-cycle check failed");

`endif

// ----- design/nog_pkg.sv -----
// shared types and constants for the occupancy grid block
// no dependencies
package nog_pkg;

  localparam int MAX_COLS   = 256;
  localparam int MAX_ROWS   = 256;
  localparam int MAX_LAYERS = 4;
  localparam int CW    = $clog2(MAX_COLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int LW    = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int AW    = LW + RW + CW;
  localparam int DEPTH = MAX_LAYERS * MAX_ROWS * MAX_COLS;
  localparam int NW    = 27;   // dividend magnitude bits
  localparam int QW    = 28;   // signed quotient bits
  localparam int DW    = 21;   // divisor bits (twice the pitch)
  localparam int KW    = $clog2(NW + 1);
  localparam int MIN_PITCH = 50;

  typedef enum logic [1:0] {
    OP_PAINT  = 2'd0,
    OP_QCELL  = 2'd1,
    OP_QPOINT = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_LIMIT_X  = 3'd2;
  localparam logic [2:0] REG_LIMIT_Y  = 3'd3;
  localparam logic [2:0] REG_PITCH    = 3'd4;
  localparam logic [2:0] REG_LAYERS   = 3'd5;
  localparam logic [2:0] REG_COLS     = 3'd6;
  localparam logic [2:0] REG_ROWS     = 3'd7;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_DECODE, ST_DIV_START, ST_DIV_RUN,
    ST_PINIT, ST_PRD, ST_PWR, ST_QRD, ST_QOUT
  } state_t;

  typedef struct packed {
    logic       load_item;
    logic       clr_step;
    logic       div_start;
    logic [1:0] div_sel;
    logic       div_store;
    logic       paint_init;
    logic       paint_rd;
    logic       paint_wr;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic clr_last;
    logic div_done;
    logic layer_bad;
    logic pt_out;
    logic paint_empty;
    logic paint_last;
    logic out_free;
  } sts_t;

endpackage

// ----- design/net_occupancy_grid.sv -----
// top level of the routing occupancy grid: sequencer plus datapath
// depends on nog_pkg, nog_ctrl, nog_dp and assert_macros.svh
//
// channel | dir | handshake        | payload
// s_*     | in  | s_tvalid/tready  | tdata items, tuser operation
// m_*     | out | m_tvalid/tready  | tdata query result
// cfg_*   | in  | cfg_we           | cfg_addr register index, cfg_data value
//
// work: a cell query reads the store once, a point query first runs two divisions,
// a paint runs four divisions, then one read-modify-write per covered cell on the
// single store port, and a clear sweeps the whole store
// reset starts a clearing sweep of all 262144 store entries, one a cycle;
// s_tready stays low until it ends, configuration writes are taken anyway
// a waiting result only stalls the next query at its output step
`include "assert_macros.svh"

module net_occupancy_grid (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  // pos_x[23:0] pos_y[47:24] size_x[67:48] size_y[87:68] col_index[97:88]
  // row_index[107:98] layer_sel[111:108] net[120:112], zero fill above
  input  logic [127:0]  s_tdata,
  // operation[1:0]
  input  logic [1:0]    s_tuser,
  output logic          m_tvalid,
  input  logic          m_tready,
  // blocked[0] cell_code[8:1], zero fill above
  output logic [15:0]   m_tdata,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_addr,
  input  logic [23:0]   cfg_data
);

  nog_pkg::cmd_t cmd;
  nog_pkg::sts_t sts;

  // sequencer: one item at a time
  nog_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // registers, divider, owner store and result register
  nog_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .sts      (sts)
  );

  // a result is only loaded when the output register is free
  `ASSERT_SAME(a_out_free, cmd.out_load, sts.out_free)
  // every store write of a paint follows its read
  `ASSERT_SAME(a_rd_before_wr, cmd.paint_wr, $past(cmd.paint_rd))
  // after a beat is taken the block is busy decoding it
  `ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)

endmodule

// ----- design/nog_ctrl.sv -----
// sequencer for the occupancy grid block
// depends on nog_pkg
module nog_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  nog_pkg::sts_t sts,
  output nog_pkg::cmd_t cmd
);

  nog_pkg::state_t state, state_next;
  logic [1:0] sel, sel_next;
  logic       sel_last;

  assign sel_last = (sts.op == nog_pkg::OP_PAINT) ? (sel == 2'd3) : (sel == 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nog_pkg::ST_CLR;
      sel   <= 2'd0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
    end
  end

  always_comb begin
    state_next = state;
    sel_next   = sel;
    case (state)
      nog_pkg::ST_CLR:  if (sts.clr_last) state_next = nog_pkg::ST_IDLE;
      nog_pkg::ST_IDLE: if (in_valid) state_next = nog_pkg::ST_DECODE;
      nog_pkg::ST_DECODE: begin
        sel_next = 2'd0;
        case (sts.op)
          nog_pkg::OP_PAINT:
            state_next = sts.layer_bad ? nog_pkg::ST_IDLE : nog_pkg::ST_DIV_START;
          nog_pkg::OP_QCELL:  state_next = nog_pkg::ST_QRD;
          nog_pkg::OP_QPOINT:
            state_next = sts.pt_out ? nog_pkg::ST_QRD : nog_pkg::ST_DIV_START;
          default:            state_next = nog_pkg::ST_CLR;
        endcase
      end
      nog_pkg::ST_DIV_START: state_next = nog_pkg::ST_DIV_RUN;
      nog_pkg::ST_DIV_RUN: begin
        if (sts.div_done) begin
          if (sel_last) begin
            state_next = (sts.op == nog_pkg::OP_PAINT) ? nog_pkg::ST_PINIT
                                                       : nog_pkg::ST_QRD;
          end else begin
            sel_next   = sel + 2'd1;
            state_next = nog_pkg::ST_DIV_START;
          end
        end
      end
      nog_pkg::ST_PINIT:
        state_next = sts.paint_empty ? nog_pkg::ST_IDLE : nog_pkg::ST_PRD;
      nog_pkg::ST_PRD: state_next = nog_pkg::ST_PWR;
      nog_pkg::ST_PWR: state_next = sts.paint_last ? nog_pkg::ST_IDLE : nog_pkg::ST_PRD;
      nog_pkg::ST_QRD: state_next = nog_pkg::ST_QOUT;
      nog_pkg::ST_QOUT: if (sts.out_free) state_next = nog_pkg::ST_IDLE;
      default: state_next = nog_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.div_sel  = sel;
    in_ready     = 1'b0;
    case (state)
      nog_pkg::ST_CLR:  cmd.clr_step = 1'b1;
      nog_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      nog_pkg::ST_DIV_START: cmd.div_start = 1'b1;
      nog_pkg::ST_DIV_RUN:   cmd.div_store = sts.div_done;
      nog_pkg::ST_PINIT:     cmd.paint_init = 1'b1;
      nog_pkg::ST_PRD:       cmd.paint_rd = 1'b1;
      nog_pkg::ST_PWR:       cmd.paint_wr = 1'b1;
      nog_pkg::ST_QOUT:      cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

endmodule

// ----- design/nog_dp.sv -----
// datapath of the occupancy grid block: registers, serial divider, owner store
// depends on nog_pkg
module nog_dp (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_addr,
  input  logic [23:0]   cfg_data,
  input  logic [127:0]  s_tdata,
  input  logic [1:0]    s_tuser,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [15:0]   m_tdata,
  input  nog_pkg::cmd_t cmd,
  output nog_pkg::sts_t sts
);

  // configuration
  logic signed [23:0] origin_x, origin_y, limit_x, limit_y;
  logic [19:0] pitch;
  logic [2:0]  layers_used;
  logic [8:0]  cols, rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0; origin_y <= '0; limit_x <= '0; limit_y <= '0;
      pitch <= 20'd100; layers_used <= 3'd1; cols <= 9'd1; rows <= 9'd1;
    end else if (cfg_we) begin
      case (cfg_addr)
        nog_pkg::REG_ORIGIN_X: origin_x <= cfg_data;
        nog_pkg::REG_ORIGIN_Y: origin_y <= cfg_data;
        nog_pkg::REG_LIMIT_X:  limit_x <= cfg_data;
        nog_pkg::REG_LIMIT_Y:  limit_y <= cfg_data;
        nog_pkg::REG_PITCH:    pitch <= cfg_data[19:0];
        nog_pkg::REG_LAYERS:   layers_used <= cfg_data[2:0];
        nog_pkg::REG_COLS:     cols <= cfg_data[8:0];
        nog_pkg::REG_ROWS:     rows <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  logic [19:0] pe;
  logic [8:0]  ec, er;
  logic [2:0]  el;
  assign pe = (pitch < 20'(nog_pkg::MIN_PITCH)) ? 20'(nog_pkg::MIN_PITCH) : pitch;
  assign ec = (cols == 9'd0) ? 9'd1 : (cols > 9'(nog_pkg::MAX_COLS)) ? 9'(nog_pkg::MAX_COLS) : cols;
  assign er = (rows == 9'd0) ? 9'd1 : (rows > 9'(nog_pkg::MAX_ROWS)) ? 9'(nog_pkg::MAX_ROWS) : rows;
  assign el = (layers_used == 3'd0) ? 3'd1
            : (layers_used > 3'(nog_pkg::MAX_LAYERS)) ? 3'(nog_pkg::MAX_LAYERS) : layers_used;

  // item registers
  nog_pkg::op_t       op;
  logic signed [23:0] pos_x, pos_y;
  logic [19:0]        size_x, size_y;
  logic signed [9:0]  col_i, row_i;
  logic signed [3:0]  layer;
  logic signed [8:0]  net;

  always_ff @(posedge clk) begin
    if (rst) begin
      op <= nog_pkg::OP_PAINT;
    end else if (cmd.load_item) begin
      op <= nog_pkg::op_t'(s_tuser);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      pos_x  <= s_tdata[23:0];
      pos_y  <= s_tdata[47:24];
      size_x <= s_tdata[67:48];
      size_y <= s_tdata[87:68];
      col_i  <= s_tdata[97:88];
      row_i  <= s_tdata[107:98];
      layer  <= s_tdata[111:108];
      net    <= s_tdata[120:112];
    end
  end

  // dividend select
  logic signed [24:0] dx, dy;
  logic signed [nog_pkg::NW-1:0] dx2, dy2, dxe, dye, sxe, sye, num;
  logic [nog_pkg::DW-1:0] den;
  logic paint_op;
  assign paint_op = (op == nog_pkg::OP_PAINT);
  assign dx  = {pos_x[23], pos_x} - {origin_x[23], origin_x};
  assign dy  = {pos_y[23], pos_y} - {origin_y[23], origin_y};
  assign dx2 = {dx[24], dx, 1'b0};
  assign dy2 = {dy[24], dy, 1'b0};
  assign dxe = {{2{dx[24]}}, dx};
  assign dye = {{2{dy[24]}}, dy};
  assign sxe = {7'b0, size_x};
  assign sye = {7'b0, size_y};
  assign den = paint_op ? {pe, 1'b0} : {1'b0, pe};

  always_comb begin
    case (cmd.div_sel)
      2'd0:    num = paint_op ? dx2 - sxe : dxe;
      2'd1:    num = paint_op ? dx2 + sxe : dye;
      2'd2:    num = dy2 - sye;
      default: num = dy2 + sye;
    endcase
  end

  // restoring divider, one quotient bit per cycle
  logic [nog_pkg::NW-1:0] quo;
  logic [nog_pkg::DW-1:0] rem, den_r;
  logic [nog_pkg::KW-1:0] cnt;
  logic                   busy, neg;
  logic [nog_pkg::DW:0]   trial, diff;
  logic                   ge;
  logic signed [nog_pkg::QW-1:0] qe, fq;
  assign trial = {rem, quo[nog_pkg::NW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};
  assign qe    = {1'b0, quo};
  // floor for negative dividends
  assign fq    = neg ? (~qe + nog_pkg::QW'(rem == '0)) : qe;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (cmd.div_start) begin
      busy <= 1'b1;
      cnt  <= nog_pkg::KW'(nog_pkg::NW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == nog_pkg::KW'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo   <= num[nog_pkg::NW-1] ? -num : num;
      neg   <= num[nog_pkg::NW-1];
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      rem <= ge ? diff[nog_pkg::DW-1:0] : trial[nog_pkg::DW-1:0];
      quo <= {quo[nog_pkg::NW-2:0], ge};
    end
  end

  logic signed [nog_pkg::QW-1:0] q_r [4];
  always_ff @(posedge clk) begin
    if (cmd.div_store) q_r[cmd.div_sel] <= fq;
  end

  // paint bounds
  logic signed [nog_pkg::QW-1:0] ecm1, ermm1, x0c, x1c, y0c, y1c;
  assign ecm1  = {{(nog_pkg::QW-9){1'b0}}, ec - 9'd1};
  assign ermm1 = {{(nog_pkg::QW-9){1'b0}}, er - 9'd1};
  assign x0c = (q_r[0] < 0) ? '0 : q_r[0];
  assign x1c = (q_r[1] > ecm1) ? ecm1 : q_r[1];
  assign y0c = (q_r[2] < 0) ? '0 : q_r[2];
  assign y1c = (q_r[3] > ermm1) ? ermm1 : q_r[3];

  logic [nog_pkg::CW-1:0] cur_c, pc0, pc1;
  logic [nog_pkg::RW-1:0] cur_r, pr1;
  always_ff @(posedge clk) begin
    if (cmd.paint_init) begin
      cur_c <= x0c[nog_pkg::CW-1:0];
      cur_r <= y0c[nog_pkg::RW-1:0];
      pc0   <= x0c[nog_pkg::CW-1:0];
      pc1   <= x1c[nog_pkg::CW-1:0];
      pr1   <= y1c[nog_pkg::RW-1:0];
    end else if (cmd.paint_wr) begin
      if (cur_c == pc1) begin
        cur_c <= pc0;
        cur_r <= cur_r + 1'b1;
      end else begin
        cur_c <= cur_c + 1'b1;
      end
    end
  end

  // query cell and bounds
  logic signed [nog_pkg::QW-1:0] qcol, qrow;
  logic signed [4:0] lay_s, el_s;
  logic layer_bad, pt_out, q_bad;
  assign qcol  = (op == nog_pkg::OP_QPOINT) ? q_r[0] : nog_pkg::QW'(col_i);
  assign qrow  = (op == nog_pkg::OP_QPOINT) ? q_r[1] : nog_pkg::QW'(row_i);
  assign lay_s = {layer[3], layer};
  assign el_s  = {2'b0, el};
  assign layer_bad = (lay_s < 0) || (lay_s >= el_s);
  assign pt_out = (pos_x < origin_x) || (pos_x > limit_x)
               || (pos_y < origin_y) || (pos_y > limit_y);
  assign q_bad = layer_bad || (qcol < 0) || (qcol > ecm1) || (qrow < 0) || (qrow > ermm1)
              || ((op == nog_pkg::OP_QPOINT) && pt_out);

  // owner store
  logic [7:0] mem [nog_pkg::DEPTH];
  logic [nog_pkg::AW-1:0] clr_addr, addr;
  logic [7:0] rdata, code, new_code, qnet, wdata;
  logic       we, blk;

  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (cmd.clr_step) clr_addr <= clr_addr + 1'b1;
  end

  assign addr = cmd.clr_step ? clr_addr
              : (cmd.paint_rd || cmd.paint_wr) ? {layer[nog_pkg::LW-1:0], cur_r, cur_c}
              : {layer[nog_pkg::LW-1:0], qrow[nog_pkg::RW-1:0], qcol[nog_pkg::CW-1:0]};

  assign code = net[8] ? 8'hFF : (net >= 9'sd253) ? 8'd254 : net[7:0] + 8'd1;
  assign new_code = (rdata == 8'd0) ? code : (rdata != code) ? 8'hFF : rdata;
  assign we    = cmd.clr_step || cmd.paint_wr;
  assign wdata = cmd.clr_step ? 8'd0 : new_code;

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

  assign qnet = net[7:0] + 8'd1;
  assign blk  = (rdata == 8'd0) ? 1'b0 : (rdata == 8'hFF) ? 1'b1 : (rdata != qnet);

  // result register
  logic       out_blk;
  logic [7:0] out_code;
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (cmd.out_load) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_blk  <= q_bad ? 1'b1 : blk;
      out_code <= q_bad ? 8'd0 : rdata;
    end
  end
  assign m_tdata = {7'b0, out_code, out_blk};

  assign sts.op          = op;
  assign sts.clr_last    = &clr_addr;
  assign sts.div_done    = !busy;
  assign sts.layer_bad   = layer_bad;
  assign sts.pt_out      = pt_out;
  assign sts.paint_empty = (x0c > x1c) || (y0c > y1c);
  assign sts.paint_last  = (cur_c == pc1) && (cur_r == pr1);
  assign sts.out_free    = !m_tvalid || m_tready;

endmodule

// ----- dv/nog_checker.sv -----
// checker for the occupancy grid: watches the config port and both streams
// keeps its own owner store, predicts each query result and compares it
`timescale 1ns / 1ps

module nog_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [127:0] s_tdata,
  input  logic [1:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [15:0]  m_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [23:0]  cfg_data,
  output int           errors,
  output int           pending
);

  typedef struct packed {
    logic       blocked;
    logic [7:0] code;
  } answer_t;

  byte unsigned owners[int];
  answer_t      answer_q[$];
  longint       org_x, org_y, lim_x, lim_y;
  longint       pitch_r, layers_r, cols_r, rows_r;

  function automatic longint floor_quot(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic longint eff_pitch();
    return (pitch_r < nog_pkg::MIN_PITCH) ? nog_pkg::MIN_PITCH : pitch_r;
  endfunction

  function automatic int cell_key(longint c, longint r, longint l);
    return int'((l * nog_pkg::MAX_ROWS + r) * nog_pkg::MAX_COLS + c);
  endfunction

  function automatic void fill_rect(longint px, longint py, longint sx, longint sy,
                                    longint layer, longint net);
    longint p2, x0, x1, y0, y1;
    byte unsigned code, cur;
    if (layer < 0 || layer >= clamp(layers_r, 1, nog_pkg::MAX_LAYERS)) return;
    p2 = 2 * eff_pitch();
    x0 = floor_quot(2 * (px - org_x) - sx, p2);
    x1 = floor_quot(2 * (px - org_x) + sx, p2);
    y0 = floor_quot(2 * (py - org_y) - sy, p2);
    y1 = floor_quot(2 * (py - org_y) + sy, p2);
    if (x0 < 0) x0 = 0;
    if (y0 < 0) y0 = 0;
    if (x1 > clamp(cols_r, 1, nog_pkg::MAX_COLS) - 1)
      x1 = clamp(cols_r, 1, nog_pkg::MAX_COLS) - 1;
    if (y1 > clamp(rows_r, 1, nog_pkg::MAX_ROWS) - 1)
      y1 = clamp(rows_r, 1, nog_pkg::MAX_ROWS) - 1;
    code = (net < 0) ? 8'd255 : (net + 1 > 254) ? 8'd254 : 8'(net + 1);
    for (longint r = y0; r <= y1; r++)
      for (longint c = x0; c <= x1; c++) begin
        cur = owners.exists(cell_key(c, r, layer)) ? owners[cell_key(c, r, layer)] : 0;
        if (cur == 0) owners[cell_key(c, r, layer)] = code;
        else if (cur != code) owners[cell_key(c, r, layer)] = 8'd255;
      end
  endfunction

  function automatic answer_t look_up(longint c, longint r, longint layer, longint net);
    answer_t a;
    byte unsigned code;
    if (c < 0 || r < 0 || c >= clamp(cols_r, 1, nog_pkg::MAX_COLS)
        || r >= clamp(rows_r, 1, nog_pkg::MAX_ROWS)
        || layer < 0 || layer >= clamp(layers_r, 1, nog_pkg::MAX_LAYERS))
      return '{blocked: 1'b1, code: 8'd0};
    code = owners.exists(cell_key(c, r, layer)) ? owners[cell_key(c, r, layer)] : 0;
    a.code = code;
    if (code == 0) a.blocked = 1'b0;
    else if (code == 255) a.blocked = 1'b1;
    else a.blocked = (code != 8'(net + 1));
    return a;
  endfunction

  function automatic void predict_beat(nog_pkg::op_t op, logic [127:0] d);
    longint px, py, sx, sy, c, r, layer, net;
    px = longint'($signed(d[23:0]));
    py = longint'($signed(d[47:24]));
    sx = longint'(d[67:48]);
    sy = longint'(d[87:68]);
    c = longint'($signed(d[97:88]));
    r = longint'($signed(d[107:98]));
    layer = longint'($signed(d[111:108]));
    net = longint'($signed(d[120:112]));
    case (op)
      nog_pkg::OP_PAINT: fill_rect(px, py, sx, sy, layer, net);
      nog_pkg::OP_QCELL: answer_q.push_back(look_up(c, r, layer, net));
      nog_pkg::OP_QPOINT: begin
        if (px < org_x || px > lim_x || py < org_y || py > lim_y)
          answer_q.push_back('{blocked: 1'b1, code: 8'd0});
        else
          answer_q.push_back(look_up(floor_quot(px - org_x, eff_pitch()),
                                     floor_quot(py - org_y, eff_pitch()), layer, net));
      end
      default: owners.delete();
    endcase
  endfunction

  always @(posedge clk) begin
    answer_t want;
    int      bad;
    bad = 0;
    if (rst) begin
      owners.delete();
      answer_q.delete();
      org_x = 0; org_y = 0; lim_x = 0; lim_y = 0;
      pitch_r = 100; layers_r = 1; cols_r = 1; rows_r = 1;
      errors <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          nog_pkg::REG_ORIGIN_X: org_x = longint'($signed(cfg_data));
          nog_pkg::REG_ORIGIN_Y: org_y = longint'($signed(cfg_data));
          nog_pkg::REG_LIMIT_X:  lim_x = longint'($signed(cfg_data));
          nog_pkg::REG_LIMIT_Y:  lim_y = longint'($signed(cfg_data));
          nog_pkg::REG_PITCH:    pitch_r = longint'(cfg_data[19:0]);
          nog_pkg::REG_LAYERS:   layers_r = longint'(cfg_data[2:0]);
          nog_pkg::REG_COLS:     cols_r = longint'(cfg_data[8:0]);
          nog_pkg::REG_ROWS:     rows_r = longint'(cfg_data[8:0]);
          default: ;
        endcase
      end
      // compare first so a result cannot match a query taken on the same edge
      if (m_tvalid && m_tready) begin
        if (answer_q.size() == 0) begin
          $error("result beat with no query waiting: %h", m_tdata);
          bad = bad + 1;
        end else begin
          want = answer_q.pop_front();
          if (m_tdata[0] !== want.blocked) begin
            $error("blocked: expected %0d actual %0d", want.blocked, m_tdata[0]);
            bad = bad + 1;
          end
          if (m_tdata[8:1] !== want.code) begin
            $error("cell_code: expected %0d actual %0d", want.code, m_tdata[8:1]);
            bad = bad + 1;
          end
        end
      end
      if (s_tvalid && s_tready) predict_beat(nog_pkg::op_t'(s_tuser), s_tdata);
      if (bad != 0) errors <= errors + bad;
    end
    pending = answer_q.size();
  end

endmodule

// ----- dv/net_occupancy_grid_test.sv -----
// top of the occupancy grid testbench: clock, reset, stimulus and verdict
// depends on nog_pkg, net_occupancy_grid and nog_checker
`timescale 1ns / 1ps

module net_occupancy_grid_test;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic [1:0]   s_tuser = nog_pkg::OP_PAINT;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [15:0]  m_tdata;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_addr = nog_pkg::REG_ORIGIN_X;
  logic [23:0]  cfg_data = '0;
  int           errors;
  int           pending;
  bit           idle_on = 1'b1;

  // shadow of the settings, used only to aim the stimulus at the grid
  longint sh_ox, sh_oy, sh_pitch, sh_layers, sh_cols, sh_rows;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  net_occupancy_grid u_dut (.*);

  nog_checker u_chk (.*);

  // result side back-pressure, m_tready low about 30 percent of the time when idling is on
  always @(posedge clk) m_tready <= !idle_on || ($urandom_range(99) >= 30);

  // hard stop in case the block hangs
  initial begin
    #100_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [127:0] pack_item(longint px, longint py, longint sx, longint sy,
                                             longint c, longint r, longint l, longint n);
    return {7'd0, 9'(n), 4'(l), 10'(r), 10'(c), 20'(sy), 20'(sx), 24'(py), 24'(px)};
  endfunction

  // one beat on the item stream, valid stays up when the next beat follows
  task automatic send_beat(nog_pkg::op_t op, logic [127:0] d);
    while (idle_on && $urandom_range(99) < 30) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= d;
    do @(posedge clk); while (!s_tready);
  endtask

  // drain results so the block is idle before registers change
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_regs(longint ox, longint oy, longint lx, longint ly,
                            longint p, longint nl, longint nc, longint nr);
    longint vals[8];
    vals = '{ox, oy, lx, ly, p, nl, nc, nr};
    for (int i = 0; i < 8; i++) begin
      cfg_we   <= 1'b1;
      cfg_addr <= 3'(i);
      cfg_data <= 24'(vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    sh_ox = ox; sh_oy = oy;
    sh_pitch = (p[19:0] < nog_pkg::MIN_PITCH) ? nog_pkg::MIN_PITCH : longint'(p[19:0]);
    sh_layers = (nl[2:0] == 0) ? 1
              : (nl[2:0] > nog_pkg::MAX_LAYERS) ? nog_pkg::MAX_LAYERS : nl[2:0];
    sh_cols = (nc[8:0] == 0) ? 1 : (nc[8:0] > nog_pkg::MAX_COLS) ? nog_pkg::MAX_COLS : nc[8:0];
    sh_rows = (nr[8:0] == 0) ? 1 : (nr[8:0] > nog_pkg::MAX_ROWS) ? nog_pkg::MAX_ROWS : nr[8:0];
  endtask

  // random beat aimed mostly inside the grid, with some raw noise
  task automatic random_beat();
    int           k;
    bit           noise;
    nog_pkg::op_t op;
    longint       px, py, sx, sy, c, r, l, n;
    k = $urandom_range(99);
    op = (k < 42) ? nog_pkg::OP_PAINT : (k < 72) ? nog_pkg::OP_QCELL : nog_pkg::OP_QPOINT;
    noise = ($urandom_range(99) < 6);
    px = sh_ox + $urandom_range(0, 32'(sh_cols * sh_pitch + 2 * sh_pitch)) - sh_pitch;
    py = sh_oy + $urandom_range(0, 32'(sh_rows * sh_pitch + 2 * sh_pitch)) - sh_pitch;
    sx = $urandom_range(0, 32'(3 * sh_pitch));
    sy = $urandom_range(0, 32'(3 * sh_pitch));
    c = longint'($urandom_range(0, 32'(sh_cols + 1))) - 1;
    r = longint'($urandom_range(0, 32'(sh_rows + 1))) - 1;
    l = ($urandom_range(9) == 0) ? longint'($urandom_range(0, 8)) - 1
                                 : longint'($urandom_range(0, 32'(sh_layers - 1)));
    k = $urandom_range(9);
    n = (k == 0) ? -1 : (k == 1) ? 253 : (k == 2) ? longint'($urandom_range(0, 511))
                                        : longint'($urandom_range(0, 4));
    if (noise) begin
      px = $urandom; py = $urandom; c = $urandom; r = $urandom;
      // whole-range sizes only where the grid is small, a paint walks every cell
      if (sh_cols * sh_rows <= 1024) begin
        sx = $urandom; sy = $urandom;
      end
    end
    if (sx > 20'hFFFFF) sx = 20'hFFFFF;
    if (sy > 20'hFFFFF) sy = 20'hFFFFF;
    send_beat(op, pack_item(px, py, sx, sy, c, r, l, n));
  endtask

  task automatic random_phase(int count);
    repeat (count) random_beat();
    // a final query marks the end of all paints before the next settings
    send_beat(nog_pkg::OP_QCELL, pack_item(0, 0, 0, 0, 0, 0, 0, 0));
    settle();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: 16 x 16 grid, pitch 100, four layers
    write_regs(0, 0, 1600, 1600, 100, 4, 16, 16);
    send_beat(nog_pkg::OP_QCELL,  pack_item(0, 0, 0, 0, 0, 0, 0, 0));          // empty cell
    send_beat(nog_pkg::OP_PAINT,  pack_item(150, 150, 100, 100, 0, 0, 0, 0));  // cells 1..2
    send_beat(nog_pkg::OP_QCELL,  pack_item(0, 0, 0, 0, 1, 1, 0, 0));          // own net
    send_beat(nog_pkg::OP_QCELL,  pack_item(0, 0, 0, 0, 2, 2, 0, 5));          // other net
    send_beat(nog_pkg::OP_PAINT,  pack_item(250, 250, 0, 0, 0, 0, 0, 7));      // collision
    send_beat(nog_pkg::OP_QCELL,  pack_item(0, 0, 0, 0, 2, 2, 0, 0));
    send_beat(nog_pkg::OP_PAINT,  pack_item(800, 800, 300, 100, 0, 0, 1, -1)); // blocks all
    send_beat(nog_pkg::OP_QCELL,  pack_item(0, 0, 0, 0, 7, 8, 1, 3));
    send_beat(nog_pkg::OP_PAINT,  pack_item(500, 500, 0, 0, 0, 0, 2, 253));    // capped code
    send_beat(nog_pkg::OP_QCELL,  pack_item(0, 0, 0, 0, 5, 5, 2, 253));
    send_beat(nog_pkg::OP_QCELL,  pack_item(0, 0, 0, 0, 5, 5, 2, 255));        // net wraps
    send_beat(nog_pkg::OP_QCELL,  pack_item(0, 0, 0, 0, 5, 5, 2, -1));
    send_beat(nog_pkg::OP_PAINT,  pack_item(500, 500, 900, 900, 0, 0, -1, 1)); // bad layers
    send_beat(nog_pkg::OP_PAINT,  pack_item(500, 500, 900, 900, 0, 0, 7, 1));
    send_beat(nog_pkg::OP_PAINT,  pack_item(0, 0, 20'hFFFFF, 20'hFFFFF, 0, 0, 3, 9));
    send_beat(nog_pkg::OP_PAINT,  pack_item(-8388608, -8388608, 20'hFFFFF, 0, 0, 0, 3, 2));
    send_beat(nog_pkg::OP_PAINT,
              pack_item(8388607, 8388607, 20'hFFFFF, 20'hFFFFF, 0, 0, 3, 2));
    send_beat(nog_pkg::OP_QCELL,  pack_item(0, 0, 0, 0, -512, 0, 3, 9));       // index range
    send_beat(nog_pkg::OP_QCELL,  pack_item(0, 0, 0, 0, 511, 15, 3, 9));
    send_beat(nog_pkg::OP_QCELL,  pack_item(0, 0, 0, 0, 15, 16, 3, 9));
    send_beat(nog_pkg::OP_QPOINT, pack_item(-1, 50, 0, 0, 0, 0, 3, 9));        // below origin
    send_beat(nog_pkg::OP_QPOINT, pack_item(1600, 1600, 0, 0, 0, 0, 3, 9));    // on the limit
    send_beat(nog_pkg::OP_QPOINT, pack_item(1599, 0, 0, 0, 0, 0, 3, 9));
    send_beat(nog_pkg::OP_CLEAR,  pack_item(0, 0, 0, 0, 0, 0, 0, 0));
    send_beat(nog_pkg::OP_QCELL,  pack_item(0, 0, 0, 0, 15, 0, 3, 9));
    settle();

    // random phases over several settings, extremes among them
    write_regs(-5000, 3000, 20000, 20000, 250, 2, 8, 12);
    random_phase(230);
    write_regs(-8388608, -8388608, 8388607, 8388607, 20'hFFFFF, 4, 16, 16);
    random_phase(230);
    idle_on = 1'b0;   // a stretch at full rate on both sides
    write_regs(1234, -777, 5000, 3000, 0, 7, 24, 20);
    random_phase(230);
    idle_on = 1'b1;
    write_regs(100, 100, 2000, 2000, 49, 0, 0, 511);
    send_beat(nog_pkg::OP_CLEAR, pack_item(0, 0, 0, 0, 0, 0, 0, 0));
    random_phase(230);
    write_regs(0, 0, 30000, 30000, 117, 3, 256, 256);
    random_phase(230);
    write_regs(8388607, 8388607, -8388608, -8388608, 60, 4, 5, 3);  // limits below origin
    random_phase(200);
    write_regs(-100000, 50000, 0, 200000, 333, 4, 40, 9);
    random_phase(230);

    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
